// ===== rtl/core/crrm_pkg.sv =====
package crrm_pkg;

    localparam int unsigned AMOUNT_W = 31;
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned DROP_W   = 32;
    localparam int unsigned CALC_W   = 17;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    localparam logic [2:0] FUNC_GET_READ  = 3'd0;
    localparam logic [2:0] FUNC_RESERVE   = 3'd1;
    localparam logic [2:0] FUNC_COMMIT    = 3'd2;
    localparam logic [2:0] FUNC_CONSUME   = 3'd3;
    localparam logic [2:0] FUNC_ADD_DROP  = 3'd4;
    localparam logic [2:0] FUNC_CLR_DROP  = 3'd5;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NONE   = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    localparam logic REG_IDX_BUFFER_SIZE = 1'b0;
    localparam logic [FIELD_W-1:0] BUFFER_SIZE_RESET = 16'd256;

    typedef struct packed {
        logic [2:0]          func;
        logic [AMOUNT_W-1:0] amount;
    } crrm_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] region_offset;
        logic [FIELD_W-1:0] region_length;
        logic [FIELD_W-1:0] data_size;
        logic [FIELD_W-1:0] free_size;
        logic [DROP_W-1:0]  dropped_total;
    } crrm_rsp_t;

endpackage

// ===== rtl/core/contiguous_ring_region_manager.sv =====
// Channel   Direction  Handshake               Word
// req       in         req_valid / req_stall   crrm_req_t (func, amount)
// rsp       out        rsp_valid / rsp_stall   crrm_rsp_t (status, region, sizes, dropped)
// apb       in/out     psel, penable, pready   buffer_size at byte address 0
//
// One word per cycle unless stalled; held in req_word_reg, its result in rsp_word_reg.
// The rate is set by the single compute stage that reads and rewrites the offset registers.
// Reset clears the offsets, the tail skip and the dropped count and sets buffer_size to 256.
// A stalled result holds the compute stage, and req_stall rises only while both stages are full.
module contiguous_ring_region_manager
    import crrm_pkg::*;
#(
    parameter int unsigned OFFSET_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  crrm_req_t             req_word,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output crrm_rsp_t             rsp_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    logic                    req_full_reg;
    logic                    req_full_next;
    crrm_req_t               req_word_reg;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    crrm_rsp_t               rsp_word_reg;
    crrm_rsp_t               rsp_word_next;

    logic [FIELD_W-1:0]      buffer_size_reg;
    logic [OFFSET_WIDTH-1:0] rd_pos_reg;
    logic [OFFSET_WIDTH-1:0] rd_pos_next;
    logic [OFFSET_WIDTH-1:0] wr_pos_reg;
    logic [OFFSET_WIDTH-1:0] wr_pos_next;
    logic [OFFSET_WIDTH-1:0] skip_reg;
    logic [OFFSET_WIDTH-1:0] skip_next;
    logic [DROP_W-1:0]       dropped_reg;
    logic [DROP_W-1:0]       dropped_next;

    logic                    advance;
    logic                    take;
    logic                    cfg_write;
    logic                    cfg_sel;

    logic [CALC_W-1:0]       s;
    logic [CALC_W-1:0]       rd;
    logic [CALC_W-1:0]       wr;
    logic [CALC_W-1:0]       sk;
    logic [CALC_W-1:0]       lsk;
    logic [CALC_W-1:0]       tail;
    logic [CALC_W-1:0]       gap;
    logic [CALC_W-1:0]       rd_avail;
    logic [CALC_W-1:0]       sum_wr;
    logic [CALC_W-1:0]       sum_rd;
    logic [CALC_W-1:0]       rd_calc;
    logic [CALC_W-1:0]       wr_calc;
    logic [CALC_W-1:0]       sk_calc;
    logic [CALC_W-1:0]       rd_post;
    logic [CALC_W-1:0]       wr_post;
    logic [CALC_W-1:0]       sk_post;
    logic [CALC_W-1:0]       lsk_post;
    logic [CALC_W-1:0]       data_calc;
    logic [CALC_W-1:0]       free_calc;
    logic [CALC_W-1:0]       roff;
    logic [CALC_W-1:0]       rlen;
    logic [AMOUNT_W-1:0]     a;
    logic [CALC_W-1:0]       a_c;
    logic [1:0]              status;

    function automatic logic [CALC_W-1:0] live_skip(
        input logic [CALC_W-1:0] size,
        input logic [CALC_W-1:0] rpos,
        input logic [CALC_W-1:0] skip
    );
        logic [CALC_W-1:0] room;
        room = size - rpos;
        return (skip > room) ? room : skip;
    endfunction

    assign cfg_sel   = (paddr[ADDR_W-1] == REG_IDX_BUFFER_SIZE);
    assign cfg_write = psel && penable && pwrite && cfg_sel;
    assign pready    = 1'b1;
    assign prdata    = (psel && cfg_sel) ? DATA_W'(buffer_size_reg) : '0;

    assign advance   = req_full_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_full_reg && !advance;
    assign take      = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    assign req_full_next  = take || (req_full_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);

    always_comb
    begin
        s        = (buffer_size_reg < FIELD_W'(2)) ? CALC_W'(2) : CALC_W'(buffer_size_reg);
        rd       = CALC_W'(rd_pos_reg);
        wr       = CALC_W'(wr_pos_reg);
        sk       = CALC_W'(skip_reg);
        a        = req_word_reg.amount;
        a_c      = CALC_W'(a);
        lsk      = live_skip(s, rd, sk);
        tail     = (rd == '0) ? (s - CALC_W'(1) - wr) : (s - wr);
        gap      = rd - wr - CALC_W'(1);
        rd_avail = s - rd - lsk;
        sum_wr   = wr + a_c;
        sum_rd   = rd + a_c;

        status       = STATUS_OK;
        roff         = '0;
        rlen         = '0;
        rd_calc      = rd;
        wr_calc      = wr;
        sk_calc      = sk;
        dropped_next = dropped_reg;

        unique case (req_word_reg.func)
            FUNC_GET_READ:
            begin
                if (rd == wr)
                begin
                    status = STATUS_NONE;
                end
                else if (rd < wr)
                begin
                    roff = rd;
                    rlen = wr - rd;
                end
                else if (rd_avail != '0)
                begin
                    roff = rd;
                    rlen = rd_avail;
                end
                else
                begin
                    rd_calc = '0;
                    if (wr == '0)
                    begin
                        status = STATUS_NONE;
                    end
                    else
                    begin
                        rlen = wr;
                    end
                end
            end
            FUNC_RESERVE:
            begin
                if (a >= AMOUNT_W'(s))
                begin
                    status = STATUS_REJECT;
                end
                else if (wr >= rd)
                begin
                    if (AMOUNT_W'(tail) >= a)
                    begin
                        sk_calc = '0;
                        roff    = wr;
                        rlen    = tail;
                    end
                    else if (AMOUNT_W'(rd) <= a)
                    begin
                        status = STATUS_NONE;
                    end
                    else
                    begin
                        sk_calc = tail;
                        wr_calc = '0;
                        if (AMOUNT_W'(rd - CALC_W'(1)) >= a)
                        begin
                            rlen = rd - CALC_W'(1);
                        end
                        else
                        begin
                            status = STATUS_NONE;
                        end
                    end
                end
                else if (AMOUNT_W'(gap) >= a)
                begin
                    roff = wr;
                    rlen = gap;
                end
                else
                begin
                    status = STATUS_NONE;
                end
            end
            FUNC_COMMIT:
            begin
                if (wr >= rd)
                begin
                    if (a > AMOUNT_W'(tail))
                    begin
                        status = STATUS_REJECT;
                    end
                    else
                    begin
                        wr_calc = (sum_wr == s) ? '0 : sum_wr;
                    end
                end
                else if (a >= AMOUNT_W'(rd - wr))
                begin
                    status = STATUS_REJECT;
                end
                else
                begin
                    wr_calc = sum_wr;
                end
            end
            FUNC_CONSUME:
            begin
                if (a == '0)
                begin
                    status = STATUS_OK;
                end
                else if (rd == wr)
                begin
                    status = STATUS_REJECT;
                end
                else if (rd > wr)
                begin
                    if (a > AMOUNT_W'(rd_avail))
                    begin
                        status = STATUS_REJECT;
                    end
                    else
                    begin
                        rd_calc = (sum_rd == (s - lsk)) ? '0 : sum_rd;
                    end
                end
                else if (a > AMOUNT_W'(wr - rd))
                begin
                    status = STATUS_REJECT;
                end
                else
                begin
                    rd_calc = sum_rd;
                end
            end
            FUNC_ADD_DROP:
            begin
                dropped_next = dropped_reg + DROP_W'(a);
            end
            FUNC_CLR_DROP:
            begin
                dropped_next = '0;
            end
            default:
            begin
                status = STATUS_REJECT;
            end
        endcase

        rd_pos_next = OFFSET_WIDTH'(rd_calc);
        wr_pos_next = OFFSET_WIDTH'(wr_calc);
        skip_next   = OFFSET_WIDTH'(sk_calc);
        rd_post     = CALC_W'(rd_pos_next);
        wr_post     = CALC_W'(wr_pos_next);
        sk_post     = CALC_W'(skip_next);
        lsk_post    = live_skip(s, rd_post, sk_post);

        if (rd_post <= wr_post)
        begin
            data_calc = wr_post - rd_post;
            free_calc = s - CALC_W'(1) - wr_post + rd_post;
        end
        else
        begin
            data_calc = s - rd_post - lsk_post + wr_post;
            free_calc = rd_post - wr_post - CALC_W'(1);
        end

        rsp_word_next.status        = status;
        rsp_word_next.region_offset = FIELD_W'(roff);
        rsp_word_next.region_length = FIELD_W'(rlen);
        rsp_word_next.data_size     = FIELD_W'(data_calc);
        rsp_word_next.free_size     = FIELD_W'(free_calc);
        rsp_word_next.dropped_total = dropped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_full_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            buffer_size_reg <= BUFFER_SIZE_RESET;
            rd_pos_reg      <= '0;
            wr_pos_reg      <= '0;
            skip_reg        <= '0;
            dropped_reg     <= '0;
        end
        else
        begin
            req_full_reg  <= req_full_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                buffer_size_reg <= pwdata[FIELD_W-1:0];
                rd_pos_reg      <= '0;
                wr_pos_reg      <= '0;
                skip_reg        <= '0;
            end
            else if (advance)
            begin
                rd_pos_reg  <= rd_pos_next;
                wr_pos_reg  <= wr_pos_next;
                skip_reg    <= skip_next;
                dropped_reg <= dropped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_word_reg <= req_word;
        end
        if (advance)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

endmodule

// ===== rtl/core/crrm_checker.sv =====
module crrm_checker
    import crrm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_stall,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input crrm_rsp_t rsp_word,
    input logic      pready
);

    // A held result must keep its word until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("stalled result word changed or vanished");

    // Back-pressure on requests only comes from a blocked result.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled while the result side is free");

    // A result that is not ok never describes a region.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status != STATUS_OK) |->
            (rsp_word.region_offset == '0) && (rsp_word.region_length == '0))
        else $error("region reported on a failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.status == STATUS_OK) || (rsp_word.status == STATUS_NONE)
            || (rsp_word.status == STATUS_REJECT))
        else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port inserted a wait state");

endmodule

bind contiguous_ring_region_manager crrm_checker u_crrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .pready    (pready)
);

// ===== bench/ring_region_checker.sv =====
module ring_region_checker
    import crrm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  crrm_req_t         req_word,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  crrm_rsp_t         rsp_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int unsigned       failures,
    output int unsigned       words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] BUFFER_SIZE_ADDR = ADDR_W'(4 * REG_IDX_BUFFER_SIZE);

    logic [FIELD_W-1:0] ring_bytes;
    logic [FIELD_W-1:0] read_at;
    logic [FIELD_W-1:0] write_at;
    logic [FIELD_W-1:0] skipped_tail;
    logic [DROP_W-1:0]  drop_tally;
    crrm_rsp_t          ring_answers[$];

    initial
    begin
        failures = 0;
        words_in_flight = 0;
    end

    // The tail skip never reaches past the end of the ring.
    function automatic logic [31:0] skip_in_force(input logic [31:0] span,
                                                  input logic [31:0] rd);
        logic [31:0] room;
        logic [31:0] skip;
        room = span - rd;
        skip = {16'd0, skipped_tail};
        return (skip > room) ? room : skip;
    endfunction

    function automatic crrm_rsp_t ring_step(input crrm_req_t word);
        logic [31:0] span;
        logic [31:0] rd;
        logic [31:0] wr;
        logic [31:0] amt;
        logic [31:0] avail;
        logic [31:0] sk;
        logic [31:0] offs;
        logic [31:0] len;
        logic [31:0] stored;
        logic [31:0] spare;
        logic        settled;
        crrm_rsp_t   answer;
        span = (ring_bytes < 2) ? 32'd2 : {16'd0, ring_bytes};
        rd = {16'd0, read_at};
        wr = {16'd0, write_at};
        amt = {1'b0, word.amount};
        offs = '0;
        len = '0;
        settled = 1'b0;
        answer = '0;
        answer.status = STATUS_OK;
        case (word.func)
            FUNC_GET_READ:
            begin
                if (rd == wr)
                begin
                    answer.status = STATUS_NONE;
                end
                else if (rd < wr)
                begin
                    offs = rd;
                    len = wr - rd;
                end
                else
                begin
                    avail = span - rd - skip_in_force(span, rd);
                    if (avail != 0)
                    begin
                        offs = rd;
                        len = avail;
                    end
                    else
                    begin
                        read_at = '0;
                        if (wr == 0)
                            answer.status = STATUS_NONE;
                        else
                            len = wr;
                    end
                end
            end
            FUNC_RESERVE:
            begin
                if (amt >= span)
                begin
                    answer.status = STATUS_REJECT;
                end
                else
                begin
                    if (wr >= rd)
                    begin
                        avail = (rd == 0) ? span - 1 - wr : span - wr;
                        if (avail >= amt)
                        begin
                            skipped_tail = '0;
                            offs = wr;
                            len = avail;
                            settled = 1'b1;
                        end
                        else if (rd <= amt)
                        begin
                            answer.status = STATUS_NONE;
                            settled = 1'b1;
                        end
                        else
                        begin
                            skipped_tail = avail[FIELD_W-1:0];
                            write_at = '0;
                            wr = '0;
                        end
                    end
                    if (!settled)
                    begin
                        if (rd - wr - 1 >= amt)
                        begin
                            offs = wr;
                            len = rd - wr - 1;
                        end
                        else
                        begin
                            answer.status = STATUS_NONE;
                        end
                    end
                end
            end
            FUNC_COMMIT:
            begin
                if (wr >= rd)
                begin
                    avail = (rd == 0) ? span - 1 - wr : span - wr;
                    if (amt > avail)
                        answer.status = STATUS_REJECT;
                    else
                        write_at = FIELD_W'((wr + amt) % span);
                end
                else
                begin
                    if (amt >= rd - wr)
                        answer.status = STATUS_REJECT;
                    else
                        write_at = FIELD_W'(wr + amt);
                end
            end
            FUNC_CONSUME:
            begin
                if (amt != 0)
                begin
                    if (rd == wr)
                    begin
                        answer.status = STATUS_REJECT;
                    end
                    else if (rd > wr)
                    begin
                        sk = skip_in_force(span, rd);
                        if (amt > span - rd - sk)
                            answer.status = STATUS_REJECT;
                        else
                            read_at = FIELD_W'((rd + amt) % (span - sk));
                    end
                    else
                    begin
                        if (amt > wr - rd)
                            answer.status = STATUS_REJECT;
                        else
                            read_at = FIELD_W'(rd + amt);
                    end
                end
            end
            FUNC_ADD_DROP:
            begin
                drop_tally = drop_tally + amt;
            end
            FUNC_CLR_DROP:
            begin
                drop_tally = '0;
            end
            default:
            begin
                answer.status = STATUS_REJECT;
            end
        endcase
        rd = {16'd0, read_at};
        wr = {16'd0, write_at};
        if (rd <= wr)
        begin
            stored = wr - rd;
            spare = span - 1 - wr + rd;
        end
        else
        begin
            stored = span - rd - skip_in_force(span, rd) + wr;
            spare = rd - wr - 1;
        end
        answer.region_offset = offs[FIELD_W-1:0];
        answer.region_length = len[FIELD_W-1:0];
        answer.data_size = stored[FIELD_W-1:0];
        answer.free_size = spare[FIELD_W-1:0];
        answer.dropped_total = drop_tally;
        return answer;
    endfunction

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", label, want, got);
            failures = failures + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        crrm_rsp_t want;
        if (!rst_n)
        begin
            ring_bytes = BUFFER_SIZE_RESET;
            read_at = '0;
            write_at = '0;
            skipped_tail = '0;
            drop_tally = '0;
            ring_answers.delete();
            words_in_flight = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == BUFFER_SIZE_ADDR)
            begin
                ring_bytes = pwdata[FIELD_W-1:0];
                read_at = '0;
                write_at = '0;
                skipped_tail = '0;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (ring_answers.size() == 0)
                begin
                    $error("result word arrived with no request outstanding");
                    failures = failures + 1;
                end
                else
                begin
                    want = ring_answers.pop_front();
                    compare_field("status", want.status, rsp_word.status);
                    compare_field("region_offset", want.region_offset,
                                  rsp_word.region_offset);
                    compare_field("region_length", want.region_length,
                                  rsp_word.region_length);
                    compare_field("data_size", want.data_size, rsp_word.data_size);
                    compare_field("free_size", want.free_size, rsp_word.free_size);
                    compare_field("dropped_total", want.dropped_total,
                                  rsp_word.dropped_total);
                end
            end
            if (req_valid && !req_stall)
                ring_answers.push_back(ring_step(req_word));
            words_in_flight = ring_answers.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
module testbench
    import crrm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] BUFFER_SIZE_ADDR = ADDR_W'(4 * REG_IDX_BUFFER_SIZE);
    localparam logic [2:0]        FUNC_UNDEF_LOW   = 3'd6;
    localparam logic [2:0]        FUNC_UNDEF_HIGH  = 3'd7;
    localparam int                WATCHDOG_LIMIT   = 5000;
    localparam int                HOLD_CYCLES      = 80;
    localparam int                DRAIN_CYCLES     = 10;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    crrm_req_t         req_word  = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    crrm_rsp_t         rsp_word;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int unsigned failures;
    int unsigned words_in_flight;
    int          idle_pct      = 0;
    int          stall_pct     = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    bit          req_taken     = 1'b0;
    bit          cfg_taken     = 1'b0;
    int unsigned ring_span     = 256;

    contiguous_ring_region_manager u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    ring_region_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_word        (req_word),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp_word        (rsp_word),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .failures        (failures),
        .words_in_flight (words_in_flight)
    );

    always
    begin
        #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        req_taken <= req_valid && !req_stall;
        cfg_taken <= psel && penable && pwrite && pready;
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // A long hold lets the block fill up while words keep being offered.
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_left = HOLD_CYCLES;
            hold_served = hold_served + 1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_word(input logic [2:0] func, input logic [31:0] amount);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word <= '{func: func, amount: amount[AMOUNT_W-1:0]};
        do
            @(negedge clk);
        while (!req_taken);
    endtask

    task automatic write_buffer_size(input logic [FIELD_W-1:0] value);
        req_valid <= 1'b0;
        while (words_in_flight != 0)
            @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BUFFER_SIZE_ADDR;
        pwdata <= {{(DATA_W-FIELD_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        ring_span = (value < 2) ? 2 : value;
    endtask

    task automatic run_phase(input logic [FIELD_W-1:0] size, input int sender_idle,
                             input int receiver_stall, input int count, input bit squeeze);
        int          sent;
        int unsigned pick;
        int unsigned span_amt;
        write_buffer_size(size);
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        if (squeeze)
            hold_requests = hold_requests + 1;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                span_amt = $urandom_range(0, ring_span - 1);
                send_word(FUNC_RESERVE, span_amt);
                send_word(FUNC_COMMIT, $urandom_range(0, span_amt));
                send_word(FUNC_GET_READ, $urandom);
                send_word(FUNC_CONSUME, $urandom_range(0, span_amt));
                sent = sent + 4;
            end
            else
            begin
                if (pick < 80)
                    send_word(FUNC_ADD_DROP, $urandom);
                else if (pick < 84)
                    send_word(FUNC_CLR_DROP, $urandom);
                else if (pick < 96)
                    send_word(3'($urandom_range(FUNC_GET_READ, FUNC_CLR_DROP)), $urandom);
                else
                    send_word(3'($urandom_range(FUNC_UNDEF_LOW, FUNC_UNDEF_HIGH)), $urandom);
                sent = sent + 1;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(FUNC_GET_READ, 0);
        send_word(FUNC_CONSUME, 0);
        send_word(FUNC_CONSUME, 5);
        send_word(FUNC_COMMIT, 300);
        send_word(FUNC_RESERVE, 256);
        send_word(FUNC_RESERVE, 32'h7FFF_FFFF);
        send_word(FUNC_RESERVE, 200);
        send_word(FUNC_COMMIT, 200);
        send_word(FUNC_GET_READ, 32'h7FFF_FFFF);
        send_word(FUNC_CONSUME, 150);
        send_word(FUNC_RESERVE, 100);
        send_word(FUNC_COMMIT, 100);
        send_word(FUNC_GET_READ, 0);
        send_word(FUNC_CONSUME, 50);
        send_word(FUNC_GET_READ, 0);
        send_word(FUNC_CONSUME, 100);
        send_word(FUNC_COMMIT, 155);
        send_word(FUNC_CONSUME, 155);
        send_word(FUNC_COMMIT, 1);
        send_word(FUNC_GET_READ, 0);
        send_word(FUNC_ADD_DROP, 32'h7FFF_FFFF);
        send_word(FUNC_ADD_DROP, 32'h7FFF_FFFF);
        send_word(FUNC_ADD_DROP, 3);
        send_word(FUNC_CLR_DROP, 32'h5555_5555);
        send_word(FUNC_UNDEF_LOW, 32'h5555_5555);
        send_word(FUNC_UNDEF_HIGH, 32'h2AAA_AAAA);
        send_word(FUNC_COMMIT, 255);
        send_word(FUNC_RESERVE, 0);

        run_phase(256, 0, 0, 150, 1'b0);
        run_phase(2, 75, 0, 150, 1'b0);
        run_phase(65535, 0, 75, 150, 1'b0);
        run_phase(17, 24, 24, 200, 1'b0);
        run_phase(5, 0, 0, 150, 1'b1);
        run_phase(300, 75, 0, 200, 1'b0);
        run_phase(64, 0, 75, 200, 1'b1);
        run_phase(3, 24, 24, 100, 1'b0);
        run_phase(1000, 0, 0, 120, 1'b0);

        req_valid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        while (words_in_flight != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== contiguous_ring_region_manager.f =====
rtl/core/crrm_pkg.sv
rtl/core/contiguous_ring_region_manager.sv
rtl/core/crrm_checker.sv
bench/ring_region_checker.sv
bench/testbench.sv
